// File: rtl/core/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the WebSocket frame deframer
// Parse phases, result kind codes and header field constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_HALT    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd32768;
  localparam logic [6:0]  LEN_CODE_EXT16    = 7'd126;
  localparam logic [6:0]  LEN_CODE_EXT64    = 7'd127;
  localparam logic [2:0]  EXT16_LAST        = 3'd1;
  localparam logic [2:0]  EXT64_LAST        = 3'd7;
  localparam logic [2:0]  MASK_LAST         = 3'd3;

endpackage

`default_nettype wire

// File: rtl/core/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket frame deframer
// Splits a received byte stream into frame headers and unmasked payload bytes.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  rx_byte
//   result    out        out_valid/out_stall  kind, opcode, frame_length,
//                                             payload_byte, last_of_frame
//   config    in         cfg_we               cfg_wdata (max_payload)
//
// One byte per cycle while in_stall is low; a result appears in the cycle after the byte that causes it.
// The header walk and the length check sit between the parse state registers
// and the single result register; the 32-bit compare sets the cycle.
// Synchronous reset returns to the first header byte and clears any halt.
// A full result register under out_stall raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wsfd_pkg::kind_t           kind,
  output logic [3:0]                opcode,
  output logic [31:0]               frame_length,
  output logic [7:0]                payload_byte,
  output logic                      last_of_frame
);

  import wsfd_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  field_count, field_count_next;
  logic [31:0] length_acc;
  logic [31:0] remaining, remaining_next;
  logic [31:0] key_word;
  logic        mask_present;
  logic [3:0]  held_opcode;
  logic [1:0]  mask_index, mask_index_next;
  logic [31:0] max_payload;

  logic        accept;
  logic [6:0]  len_code;
  logic [31:0] len_new;
  logic        length_done;
  logic        mask_now;
  logic        hdr_end;
  logic        oversize;
  logic        pay_last;
  logic [31:0] remaining_dec;
  logic [7:0]  key_byte;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_last;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign len_code = rx_byte[6:0];

  always_comb begin
    len_new     = length_acc;
    length_done = 1'b0;
    mask_now    = mask_present;
    unique case (phase)
      PH_HDR1: begin
        mask_now = rx_byte[7];
        if (len_code == LEN_CODE_EXT16 || len_code == LEN_CODE_EXT64) begin
          len_new = '0;
        end else begin
          len_new     = {25'd0, len_code};
          length_done = 1'b1;
        end
      end
      PH_EXT16: begin
        len_new     = {16'd0, length_acc[7:0], rx_byte};
        length_done = (field_count >= EXT16_LAST);
      end
      PH_EXT64: begin
        len_new     = {length_acc[23:0], rx_byte};
        length_done = (field_count >= EXT64_LAST);
      end
      default: begin
      end
    endcase
  end

  assign hdr_end = (length_done && !mask_now) ||
                   (phase == PH_MASK && field_count >= MASK_LAST);
  assign oversize      = len_new > max_payload;
  assign remaining_dec = remaining - 32'd1;
  assign pay_last      = (remaining_dec == '0);

  always_comb begin
    unique case (mask_index)
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
    if (!mask_present) begin
      key_byte = '0;
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    remaining_next   = remaining;
    mask_index_next  = mask_index;
    unique case (phase)
      PH_HDR0: begin
        phase_next = PH_HDR1;
      end
      PH_HDR1, PH_EXT16, PH_EXT64: begin
        if (phase == PH_HDR1) begin
          field_count_next = '0;
          if (len_code == LEN_CODE_EXT16) begin
            phase_next = PH_EXT16;
          end else if (len_code == LEN_CODE_EXT64) begin
            phase_next = PH_EXT64;
          end
        end else if (!length_done) begin
          field_count_next = field_count + 3'd1;
        end
        if (length_done) begin
          field_count_next = '0;
          if (mask_now) begin
            phase_next = PH_MASK;
          end
        end
      end
      PH_MASK: begin
        if (hdr_end) begin
          field_count_next = '0;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        mask_index_next = mask_index + 2'd1;
        remaining_next  = remaining_dec;
        if (pay_last) begin
          phase_next = PH_HDR0;
        end
      end
      PH_HALT: begin
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
    if (hdr_end) begin
      if (oversize) begin
        phase_next = PH_HALT;
      end else if (len_new == '0) begin
        phase_next = PH_HDR0;
      end else begin
        phase_next      = PH_PAYLOAD;
        remaining_next  = len_new;
        mask_index_next = '0;
      end
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_HEADER;
    res_byte  = '0;
    res_last  = 1'b0;
    if (phase == PH_PAYLOAD) begin
      res_valid = 1'b1;
      res_kind  = KIND_PAYLOAD;
      res_byte  = rx_byte ^ key_byte;
      res_last  = pay_last;
    end else if (hdr_end) begin
      res_valid = 1'b1;
      if (oversize) begin
        res_kind = KIND_ERROR;
      end else begin
        res_last = (len_new == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      field_count  <= '0;
      length_acc   <= '0;
      remaining    <= '0;
      key_word     <= '0;
      mask_present <= 1'b0;
      held_opcode  <= '0;
      mask_index   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      field_count <= field_count_next;
      length_acc  <= len_new;
      remaining   <= remaining_next;
      mask_index  <= mask_index_next;
      if (phase == PH_HDR0) begin
        held_opcode <= rx_byte[3:0];
      end
      if (phase == PH_HDR1) begin
        mask_present <= rx_byte[7];
      end
      if (phase == PH_MASK) begin
        key_word <= {key_word[23:0], rx_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind          <= res_kind;
      opcode        <= held_opcode;
      frame_length  <= len_new;
      payload_byte  <= res_byte;
      last_of_frame <= res_last;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HALT |=> !out_valid)
    else $error("result after halt");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> phase == PH_HALT && frame_length > max_payload)
    else $error("error result without halt or oversize length");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD && last_of_frame |-> phase == PH_HDR0)
    else $error("last payload byte did not return to header");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for websocket_frame_deframer
// Feeds WebSocket byte streams (short, 16-bit and 64-bit lengths, masked and
// unmasked, empty frames, guarded random bytes) through the in_valid/in_stall
// channel and checks every header, payload and error transfer against an
// in-bench frame decoder. Sweeps max_payload across its extremes and ends on
// an oversize frame, after which all input must be dropped.
// ----------------------------------------------------------------------------
module testbench;
  import wsfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_EXT16 = 2'd1,
    FORM_EXT64 = 2'd2
  } len_form_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  opcode;
    logic [31:0] flen;
    logic [7:0]  pbyte;
    logic        last;
  } deframe_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       kind;
  logic [3:0]  opcode;
  logic [31:0] frame_length;
  logic [7:0]  payload_byte;
  logic        last_of_frame;

  websocket_frame_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .opcode        (opcode),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame)
  );

  // decoder state
  phase_t      ph = PH_HDR0;
  logic [2:0]  fcnt = 3'd0;
  logic [31:0] len_acc = 32'd0;
  logic [31:0] remain = 32'd0;
  logic [31:0] mkey = 32'd0;
  logic        mpresent = 1'b0;
  logic [3:0]  op = 4'd0;
  logic [1:0]  midx = 2'd0;
  logic        halted = 1'b0;
  logic [31:0] max_len = MAX_PAYLOAD_RESET;

  deframe_result_t expected_results[$];
  deframe_result_t want;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          idle_pct = 21;
  int          cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic void queue_result(kind_t k, logic [7:0] pb, logic last);
    deframe_result_t r;
    r.kind   = k;
    r.opcode = op;
    r.flen   = len_acc;
    r.pbyte  = pb;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  function automatic void close_header();
    if (len_acc > max_len) begin
      ph = PH_HALT;
      halted = 1'b1;
      queue_result(KIND_ERROR, 8'd0, 1'b0);
    end else if (len_acc == 32'd0) begin
      ph = PH_HDR0;
      queue_result(KIND_HEADER, 8'd0, 1'b1);
    end else begin
      remain = len_acc;
      midx = 2'd0;
      ph = PH_PAYLOAD;
      queue_result(KIND_HEADER, 8'd0, 1'b0);
    end
  endfunction

  function automatic void end_of_length();
    fcnt = 3'd0;
    if (mpresent) begin
      mkey = 32'd0;
      ph = PH_MASK;
    end else begin
      close_header();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] kb;
    if (halted) return;
    case (ph)
      PH_HDR1: begin
        mpresent = b[7];
        fcnt = 3'd0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          len_acc = 32'd0;
          ph = PH_EXT16;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          len_acc = 32'd0;
          ph = PH_EXT64;
        end else begin
          len_acc = {25'd0, b[6:0]};
          end_of_length();
        end
      end
      PH_EXT16: begin
        len_acc = {16'd0, len_acc[7:0], b};
        if (fcnt >= EXT16_LAST) end_of_length();
        else fcnt = fcnt + 3'd1;
      end
      PH_EXT64: begin
        len_acc = {len_acc[23:0], b};
        if (fcnt >= EXT64_LAST) end_of_length();
        else fcnt = fcnt + 3'd1;
      end
      PH_MASK: begin
        mkey = {mkey[23:0], b};
        if (fcnt >= MASK_LAST) begin
          fcnt = 3'd0;
          close_header();
        end else begin
          fcnt = fcnt + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        kb = mpresent ? mkey[8*(3-midx) +: 8] : 8'd0;
        midx = midx + 2'd1;
        remain = remain - 32'd1;
        if (remain == 32'd0) begin
          ph = PH_HDR0;
          queue_result(KIND_PAYLOAD, b ^ kb, 1'b1);
        end else begin
          queue_result(KIND_PAYLOAD, b ^ kb, 1'b0);
        end
      end
      PH_HALT: ;
      default: begin
        op = b[3:0];
        ph = PH_HDR1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, exp_val,
               cycle_count);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", {30'd0, kind}, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind)
          report_mismatch("kind", {30'd0, kind}, {30'd0, want.kind});
        if (opcode !== want.opcode)
          report_mismatch("opcode", {28'd0, opcode}, {28'd0, want.opcode});
        if (frame_length !== want.flen)
          report_mismatch("frame_length", frame_length, want.flen);
        if (payload_byte !== want.pbyte)
          report_mismatch("payload_byte", {24'd0, payload_byte}, {24'd0, want.pbyte});
        if (last_of_frame !== want.last)
          report_mismatch("last_of_frame", {31'd0, last_of_frame}, {31'd0, want.last});
      end
    end
  end

  // call at a falling edge; returns at a falling edge with in_valid still high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_max_payload(input logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    max_len = value;
  endtask

  task automatic send_frame(input logic [7:0] first, input logic masked, input len_form_t form,
                            input logic [31:0] len, input logic [31:0] upper);
    logic [31:0] key;
    logic [31:0] n;
    key = $urandom;
    send_byte(first);
    case (form)
      FORM_EXT16: begin
        send_byte({masked, LEN_CODE_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, LEN_CODE_EXT64});
        for (int i = 3; i >= 0; i--) send_byte(upper[8*i +: 8]);
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    n = (len > max_len) ? 32'd0 : len;
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame(input logic [31:0] cap);
    len_form_t   form;
    logic [31:0] len;
    int          pick;
    pick = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
    if (pick < 60) begin
      form = FORM_SHORT;
    end else if (pick < 85) begin
      form = FORM_EXT16;
      if ($urandom_range(7) == 0) len = $urandom_range(300, 256);
    end else begin
      form = FORM_EXT64;
    end
    if (len > cap) len = cap;
    send_frame(8'($urandom), 1'($urandom), form, len, $urandom);
  endtask

  // raw bytes, held to lengths of at most 255
  task automatic send_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = $urandom;
      if (ph == PH_HDR1 && b[6:0] < LEN_CODE_EXT16) b[6:5] = 2'b00;
      else if (ph == PH_EXT16 && fcnt == 3'd0) b = 8'h00;
      else if (ph == PH_EXT64 && fcnt >= 3'd4 && fcnt < EXT64_LAST) b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic random_traffic(input int count, input logic [31:0] cap, input bit quiet_run);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if (quiet_run && bytes_sent > stop_at - 2 * count / 3 && bytes_sent < stop_at - count / 4)
        idle_pct = 0;
      else
        idle_pct = 21;
      if (cap >= 300 && $urandom_range(99) < 15) begin
        send_noise($urandom_range(8, 1));
        while (ph != PH_HDR0) send_noise(1);
      end else begin
        send_random_frame(cap);
      end
    end
    idle_pct = 21;
    while (ph != PH_HDR0) send_noise(1);
  endtask

  task automatic test_unmasked_frame();
    send_frame(8'hFF, 1'b0, FORM_SHORT, 32'd2, 32'd0);
  endtask

  task automatic test_masked_frame();
    send_frame(8'h00, 1'b1, FORM_SHORT, 32'd5, 32'd0);
  endtask

  task automatic test_empty_frame();
    send_frame(8'h89, 1'b0, FORM_SHORT, 32'd0, 32'd0);
  endtask

  task automatic test_ext16_length();
    send_frame(8'h02, 1'b0, FORM_EXT16, 32'd3, 32'd0);
  endtask

  task automatic test_wide_limit();
    write_max_payload(32'hFFFF_FFFF);
    send_frame(8'h81, 1'b1, FORM_EXT64, 32'd4, 32'hFFFF_FFFF);
    send_frame(8'h7E, 1'b0, FORM_EXT64, 32'd1, $urandom);
    random_traffic(150, 32'd300, 1'b0);
  endtask

  task automatic test_length_at_limit();
    write_max_payload(32'd5);
    send_frame(8'h82, 1'b1, FORM_SHORT, 32'd5, 32'd0);
    send_frame(8'h01, 1'b0, FORM_EXT16, 32'd5, 32'd0);
    send_frame(8'h08, 1'b1, FORM_EXT64, 32'd5, $urandom);
    random_traffic(120, 32'd5, 1'b0);
  endtask

  task automatic test_random_frames();
    write_max_payload($urandom_range(70000, 300));
    random_traffic(600, 32'd300, 1'b1);
  endtask

  task automatic test_oversize_halt();
    write_max_payload(32'd0);
    send_frame(8'h88, 1'b0, FORM_SHORT, 32'd0, 32'd0);
    send_frame(8'h8A, 1'b1, FORM_EXT16, 32'd0, 32'd0);
    send_frame(8'($urandom), 1'b0, FORM_EXT64, 32'd0, 32'hFFFF_FFFF);
    send_frame(8'h81, 1'b1, FORM_EXT64, 32'hFFFF_FFFF, $urandom);
    send_noise(12);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_unmasked_frame();
    test_masked_frame();
    test_empty_frame();
    test_ext16_length();
    test_wide_limit();
    test_length_at_limit();
    test_random_frames();
    test_oversize_halt();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
